// ===== sv/bfvl_pkg.sv =====
// Package for the battery full-voltage learner: the sequencer state type,
// register indexes, field widths and reset values.
// No dependencies; the top level imports it.
`default_nettype none

package bfvl_pkg;

    // Field widths.
    localparam int MV_W   = 13;
    localparam int BAND_W = 8;

    // Register reset values.
    localparam logic [MV_W-1:0]   FULL_INIT_RST = 13'd4020;
    localparam logic [MV_W-1:0]   PLAT_MIN_RST  = 13'd3900;
    localparam logic [BAND_W-1:0] PLAT_BAND_RST = 8'd6;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_FULL_INIT = 2'd0;
    localparam logic [1:0] REG_PLAT_MIN  = 2'd1;
    localparam logic [1:0] REG_PLAT_BAND = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } fsm_state_t;

endpackage

`default_nettype wire

// ===== sv/battery_full_voltage_learner.sv =====
// Battery full-voltage learner: sample ring, moving mean, trend window and plateau check.
// Each valid sample is summed over the sample ring, divided by the fill count in a radix-4
// divider and committed once the trend walk is over; a zero sample goes straight to commit.
// A new sample is taken only after the last one is committed, and the commit waits on any
// output stall. Reset clears pointers, fill counts, control and configuration registers;
// the payload registers and the rings need no clearing. Depends on bfvl_pkg.
`default_nettype none

module battery_full_voltage_learner #(
    parameter int AVG_WINDOW   = 11,
    parameter int TREND_WINDOW = 20
) (
    input  wire         clk,
    input  wire         rst_n,
    // Sample stream. tdata: [12:0] battery_mv, [13] powered, [15:14] zero.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,
    // Result stream. tdata: [0] sample_ok, [13:1] average_mv, [26:14] full_mv,
    // [27] learned, [31:28] zero.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfvl_pkg::*;

    // Derived widths.
    localparam int AW        = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int FW        = $clog2(AVG_WINDOW + 1);
    localparam int SUMW      = MV_W + FW;
    localparam int DIV_STEPS = (SUMW + 1) / 2;
    localparam int DQW       = 2 * DIV_STEPS;
    localparam int DCW       = $clog2(DIV_STEPS + 1);
    localparam int TW        = $clog2(TREND_WINDOW);
    localparam int TFW       = $clog2(TREND_WINDOW + 1);

    localparam logic [AW-1:0]  SPOS_LAST  = AW'(AVG_WINDOW - 1);
    localparam logic [FW-1:0]  SFILL_MAX  = FW'(AVG_WINDOW);
    localparam logic [DCW-1:0] DIV_LAST   = DCW'(DIV_STEPS - 1);
    localparam logic [TW-1:0]  TPOS_LAST  = TW'(TREND_WINDOW - 1);
    localparam logic [TFW-1:0] TFILL_MAX  = TFW'(TREND_WINDOW);
    localparam logic [TFW-1:0] TFILL_NEAR = TFW'(TREND_WINDOW - 1);

    // Ring memories and their registered read data.
    logic [MV_W-1:0] sample_mem [AVG_WINDOW];
    logic [MV_W-1:0] trend_mem  [TREND_WINDOW];
    logic [MV_W-1:0] sample_q_reg;
    logic [MV_W-1:0] trend_q_reg;
    logic            sample_we;
    logic            sample_re;
    logic            trend_we;

    // Sequencer and datapath registers.
    fsm_state_t        state_reg, state_next;
    logic [AW-1:0]     spos_reg, spos_next;
    logic [FW-1:0]     sfill_reg, sfill_next;
    logic [FW-1:0]     sum_idx_reg, sum_idx_next;
    logic              sum_pend_reg, sum_pend_next;
    logic [SUMW-1:0]   acc_reg, acc_next;
    logic [DQW-1:0]    quo_reg, quo_next;
    logic [FW-1:0]     rem_reg, rem_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic [TW-1:0]     tpos_reg, tpos_next;
    logic [TFW-1:0]    tfill_reg, tfill_next;
    logic [TW-1:0]     scan_idx_reg, scan_idx_next;
    logic              scan_busy_reg, scan_busy_next;
    logic              scan_pend_reg, scan_pend_next;
    logic              scan_have_reg, scan_have_next;
    logic [MV_W-1:0]   lo_reg, lo_next;
    logic [MV_W-1:0]   hi_reg, hi_next;
    logic              powered_reg, powered_next;
    logic              ok_reg, ok_next;
    logic [MV_W-1:0]   learned_reg, learned_next;
    logic [MV_W-1:0]   full_init_reg, full_init_next;
    logic [MV_W-1:0]   plat_min_reg, plat_min_next;
    logic [BAND_W-1:0] plat_band_reg, plat_band_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;

    // Working signals.
    logic [MV_W-1:0] in_mv;
    logic            out_free;
    logic            cfg_wr;
    logic [MV_W-1:0] mean;
    logic [MV_W-1:0] lo_all;
    logic [MV_W-1:0] hi_all;
    logic            flat;
    logic            learn;
    logic [MV_W-1:0] full_after;

    assign in_mv    = s_axis_tdata[MV_W-1:0];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign mean     = quo_reg[MV_W-1:0];

    // Two restoring division steps per cycle.
    function automatic logic [FW+DQW-1:0] div_step2(input logic [FW-1:0] r_in,
                                                     input logic [DQW-1:0] q_in,
                                                     input logic [FW-1:0] dvs);
        logic [FW:0]     trial;
        logic [FW-1:0]   r;
        logic [DQW-1:0]  q;
        r = r_in;
        q = q_in;
        for (int i = 0; i < 2; i++)
        begin
            trial = {r, q[DQW-1]};
            q     = {q[DQW-2:0], 1'b0};
            if (trial >= {1'b0, dvs})
            begin
                trial = trial - {1'b0, dvs};
                q[0]  = 1'b1;
            end
            r = trial[FW-1:0];
        end
        return {r, q};
    endfunction

    // Plateau check over the walked trend entries plus the new mean.
    always_comb
    begin
        lo_all = (mean < lo_reg) ? mean : lo_reg;
        hi_all = (mean > hi_reg) ? mean : hi_reg;
        flat   = (hi_all - lo_all) <= {{(MV_W-BAND_W){1'b0}}, plat_band_reg};
        learn  = powered_reg && (tfill_reg >= TFILL_NEAR) && (mean >= plat_min_reg)
                 && flat && (mean != learned_reg);
        full_after = learn ? mean : learned_reg;
    end

    // Sequencer: next state, sample walk, divider and commit.
    always_comb
    begin
        state_next     = state_reg;
        spos_next      = spos_reg;
        sfill_next     = sfill_reg;
        sum_idx_next   = sum_idx_reg;
        sum_pend_next  = sum_pend_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        tpos_next      = tpos_reg;
        tfill_next     = tfill_reg;
        powered_next   = powered_reg;
        ok_next        = ok_reg;
        learned_next   = learned_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        sample_we      = 1'b0;
        sample_re      = 1'b0;
        trend_we       = 1'b0;
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    powered_next = s_axis_tdata[MV_W];
                    ok_next      = (in_mv != '0);
                    if (in_mv != '0)
                    begin
                        sample_we     = 1'b1;
                        spos_next     = (spos_reg == SPOS_LAST) ? '0 : spos_reg + 1'b1;
                        sfill_next    = (sfill_reg == SFILL_MAX) ? sfill_reg : sfill_reg + 1'b1;
                        sum_idx_next  = '0;
                        sum_pend_next = 1'b0;
                        acc_next      = '0;
                        state_next    = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SUM:
            begin
                // One read issued per cycle, accumulated in the cycle after.
                sum_pend_next = 1'b0;
                if (sum_idx_reg != sfill_reg)
                begin
                    sample_re     = 1'b1;
                    sum_idx_next  = sum_idx_reg + 1'b1;
                    sum_pend_next = 1'b1;
                end
                if (sum_pend_reg)
                begin
                    acc_next = acc_reg + {{FW{1'b0}}, sample_q_reg};
                end
                if ((sum_idx_reg == sfill_reg) && !sum_pend_reg)
                begin
                    quo_next     = DQW'(acc_reg);
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end

            ST_DIV:
            begin
                {rem_next, quo_next} = div_step2(rem_reg, quo_reg, sfill_reg);
                div_cnt_next         = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Commit once the trend walk is over and the output register is free.
                if (!scan_busy_reg && !scan_pend_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (ok_reg)
                    begin
                        trend_we      = 1'b1;
                        tpos_next     = (tpos_reg == TPOS_LAST) ? '0 : tpos_reg + 1'b1;
                        tfill_next    = (tfill_reg == TFILL_MAX) ? tfill_reg
                                                                 : tfill_reg + 1'b1;
                        learned_next  = full_after;
                        out_data_next = {4'b0, learn, full_after, mean, 1'b1};
                    end
                    else
                    begin
                        out_data_next = {4'b0, 1'b0, learned_reg, {MV_W{1'b0}}, 1'b0};
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A write of the initial full voltage reloads the learned value.
        if (cfg_wr && (paddr[3:2] == REG_FULL_INIT))
        begin
            learned_next = pwdata[MV_W-1:0];
        end
    end

    // Trend walk: min and max over every entry but the one about to be replaced.
    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        scan_busy_next = scan_busy_reg;
        scan_pend_next = 1'b0;
        scan_have_next = scan_have_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;

        if (scan_busy_reg)
        begin
            scan_pend_next = (scan_idx_reg != tpos_reg);
            if (scan_idx_reg == TPOS_LAST)
            begin
                scan_busy_next = 1'b0;
            end
            else
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end

        if (scan_pend_reg)
        begin
            if (!scan_have_reg || (trend_q_reg < lo_reg))
            begin
                lo_next = trend_q_reg;
            end
            if (!scan_have_reg || (trend_q_reg > hi_reg))
            begin
                hi_next = trend_q_reg;
            end
            scan_have_next = 1'b1;
        end

        // Start the walk with each valid sample.
        if ((state_reg == ST_IDLE) && s_axis_tvalid && (in_mv != '0))
        begin
            scan_idx_next  = '0;
            scan_busy_next = 1'b1;
            scan_pend_next = 1'b0;
            scan_have_next = 1'b0;
        end
    end

    // Configuration register writes.
    always_comb
    begin
        full_init_next = full_init_reg;
        plat_min_next  = plat_min_reg;
        plat_band_next = plat_band_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FULL_INIT: full_init_next = pwdata[MV_W-1:0];
                REG_PLAT_MIN:  plat_min_next  = pwdata[MV_W-1:0];
                REG_PLAT_BAND: plat_band_next = pwdata[BAND_W-1:0];
                default:       full_init_next = full_init_reg;
            endcase
        end
    end

    // Configuration reads.
    always_comb
    begin
        pready = 1'b1;
        case (paddr[3:2])
            REG_FULL_INIT: prdata = {{(32-MV_W){1'b0}}, full_init_reg};
            REG_PLAT_MIN:  prdata = {{(32-MV_W){1'b0}}, plat_min_reg};
            REG_PLAT_BAND: prdata = {{(32-BAND_W){1'b0}}, plat_band_reg};
            default:       prdata = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spos_reg      <= '0;
            sfill_reg     <= '0;
            sum_idx_reg   <= '0;
            sum_pend_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            tpos_reg      <= '0;
            tfill_reg     <= '0;
            scan_idx_reg  <= '0;
            scan_busy_reg <= 1'b0;
            scan_pend_reg <= 1'b0;
            scan_have_reg <= 1'b0;
            ok_reg        <= 1'b0;
            learned_reg   <= FULL_INIT_RST;
            full_init_reg <= FULL_INIT_RST;
            plat_min_reg  <= PLAT_MIN_RST;
            plat_band_reg <= PLAT_BAND_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            spos_reg      <= spos_next;
            sfill_reg     <= sfill_next;
            sum_idx_reg   <= sum_idx_next;
            sum_pend_reg  <= sum_pend_next;
            div_cnt_reg   <= div_cnt_next;
            tpos_reg      <= tpos_next;
            tfill_reg     <= tfill_next;
            scan_idx_reg  <= scan_idx_next;
            scan_busy_reg <= scan_busy_next;
            scan_pend_reg <= scan_pend_next;
            scan_have_reg <= scan_have_next;
            ok_reg        <= ok_next;
            learned_reg   <= learned_next;
            full_init_reg <= full_init_next;
            plat_min_reg  <= plat_min_next;
            plat_band_reg <= plat_band_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        powered_reg  <= powered_next;
        out_data_reg <= out_data_next;
    end

    // Sample ring memory: written on a transfer of a nonzero sample, read during the sum walk.
    always_ff @(posedge clk)
    begin
        if (sample_we)
        begin
            sample_mem[spos_reg] <= in_mv;
        end
        if (sample_re)
        begin
            sample_q_reg <= sample_mem[sum_idx_reg[AW-1:0]];
        end
    end

    // Trend ring memory: written at commit, read during the trend walk.
    always_ff @(posedge clk)
    begin
        if (trend_we)
        begin
            trend_mem[tpos_reg] <= mean;
        end
        if (scan_busy_reg)
        begin
            trend_q_reg <= trend_mem[scan_idx_reg];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
